>>> rtl/qpd_pkg.sv
// ============================================================================
// Quoted-printable decoder package
// Shared types, constants and character helpers for the line decoder.
// ============================================================================
`default_nettype none

package qpd_pkg;

   // width of the internal decoded-byte counter (saturates at all ones)
   localparam int LENGTH_WIDTH = 16;
   // width of the reported line length field
   localparam int REPORT_WIDTH = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_EQUALS = 8'h3D;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_EQ    = 2'd1,
      MODE_HEX   = 2'd2,
      MODE_SOFT  = 2'd3
   } qpd_mode_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_line;
   } qpd_req_type;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              decoded_byte;
      logic [REPORT_WIDTH-1:0] line_length;
      logic                    soft_break;
      logic                    last;
   } qpd_rsp_type;

   // one accepted item's worth of results: num results (1..3); when report
   // is set the final one is the end-of-line report
   typedef struct packed {
      logic [1:0]              num;
      logic [7:0]              data0;
      logic [7:0]              data1;
      logic [7:0]              data2;
      logic                    report;
      logic                    soft_end;
      logic [REPORT_WIDTH-1:0] length;
   } qpd_entry_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c <= 8'h39) begin
         v = c[3:0];
      end else begin
         v = 4'(c[3:0] + 4'd9);
      end
      return v;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

`default_nettype wire

>>> rtl/qpd_front.sv
// ============================================================================
// Decoder front end
// Accepts encoded bytes, runs the escape state machine and line counter,
// and pushes each item's results as one entry into the queue.
// ============================================================================
`default_nettype none

module qpd_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  qpd_pkg::qpd_req_type    req_payload,
   output logic                    req_stall,
   input  wire                     queue_full,
   output logic                    push,
   output qpd_pkg::qpd_entry_type  push_entry
);

   localparam int LW = qpd_pkg::LENGTH_WIDTH;

   qpd_pkg::qpd_mode_type mode_ff, mode_in;
   logic [7:0]            held_ff, held_in;
   logic [LW-1:0]         count_ff, count_in;

   logic                  accept;
   logic [1:0]            nbytes;
   logic [LW:0]           sum;
   logic [LW-1:0]         count_sat;
   logic [32:0]           count_wide;
   logic [7:0]            c;
   qpd_pkg::qpd_entry_type e;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign c         = req_payload.byte_in;

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      nbytes  = 2'd0;
      e       = '0;
      if (req_payload.end_of_line) begin
         mode_in = qpd_pkg::MODE_PLAIN;
         held_in = '0;
         e.report = 1'b1;
         unique case (mode_ff)
            qpd_pkg::MODE_EQ, qpd_pkg::MODE_SOFT: begin
               e.soft_end = 1'b1;
            end
            qpd_pkg::MODE_HEX: begin
               e.data0 = qpd_pkg::CHAR_EQUALS;
               e.data1 = held_ff;
               nbytes  = 2'd2;
            end
            qpd_pkg::MODE_PLAIN: begin
            end
         endcase
      end else begin
         unique case (mode_ff)
            qpd_pkg::MODE_PLAIN: begin
               if (c == qpd_pkg::CHAR_EQUALS) begin
                  mode_in = qpd_pkg::MODE_EQ;
               end else begin
                  e.data0 = c;
                  nbytes  = 2'd1;
               end
            end
            qpd_pkg::MODE_EQ: begin
               if (qpd_pkg::is_hex(c)) begin
                  held_in = c;
                  mode_in = qpd_pkg::MODE_HEX;
               end else if (qpd_pkg::is_space(c)) begin
                  mode_in = qpd_pkg::MODE_SOFT;
               end else begin
                  // broken escape: '=' goes out literally, byte re-read as plain
                  e.data0 = qpd_pkg::CHAR_EQUALS;
                  if (c == qpd_pkg::CHAR_EQUALS) begin
                     mode_in = qpd_pkg::MODE_EQ;
                     nbytes  = 2'd1;
                  end else begin
                     mode_in = qpd_pkg::MODE_PLAIN;
                     e.data1 = c;
                     nbytes  = 2'd2;
                  end
               end
            end
            qpd_pkg::MODE_HEX: begin
               held_in = '0;
               mode_in = qpd_pkg::MODE_PLAIN;
               if (qpd_pkg::is_hex(c)) begin
                  e.data0 = {qpd_pkg::hex_value(held_ff), qpd_pkg::hex_value(c)};
                  nbytes  = 2'd1;
               end else begin
                  e.data0 = qpd_pkg::CHAR_EQUALS;
                  e.data1 = held_ff;
                  if (c == qpd_pkg::CHAR_EQUALS) begin
                     mode_in = qpd_pkg::MODE_EQ;
                     nbytes  = 2'd2;
                  end else begin
                     e.data2 = c;
                     nbytes  = 2'd3;
                  end
               end
            end
            qpd_pkg::MODE_SOFT: begin
            end
         endcase
      end

      // saturating add of this item's bytes
      sum        = {1'b0, count_ff} + (LW + 1)'(nbytes);
      count_sat  = sum[LW] ? '1 : sum[LW-1:0];
      count_wide = 33'(count_sat);
      e.length   = (count_wide > 33'hFFFF) ? '1 : count_wide[15:0];
      e.num      = 2'(nbytes + 2'(e.report));
      count_in   = req_payload.end_of_line ? '0 : count_sat;
   end

   assign push       = accept && (e.num != 2'd0);
   assign push_entry = e;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qpd_pkg::MODE_PLAIN;
         held_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/qpd_queue.sv
// ============================================================================
// Result entry queue
// Small register FIFO between the front end and the output stage.
// ============================================================================
`default_nettype none

module qpd_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  qpd_pkg::qpd_entry_type  push_entry,
   input  wire                     pop,
   output qpd_pkg::qpd_entry_type  head,
   output logic                    empty,
   output logic                    full
);

   qpd_pkg::qpd_entry_type mem_ff [qpd_pkg::QUEUE_DEPTH];

   logic [qpd_pkg::QPTR_WIDTH-1:0] wr_ff, rd_ff;
   logic [qpd_pkg::QCNT_WIDTH-1:0] cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == qpd_pkg::QCNT_WIDTH'(qpd_pkg::QUEUE_DEPTH));
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= qpd_pkg::QPTR_WIDTH'(wr_ff + 1'b1);
         end
         if (pop) begin
            rd_ff <= qpd_pkg::QPTR_WIDTH'(rd_ff + 1'b1);
         end
         if (push && !pop) begin
            cnt_ff <= qpd_pkg::QCNT_WIDTH'(cnt_ff + 1'b1);
         end else if (pop && !push) begin
            cnt_ff <= qpd_pkg::QCNT_WIDTH'(cnt_ff - 1'b1);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/qpd_back.sv
// ============================================================================
// Decoder output stage
// Walks each entry into the output register one result per unstalled cycle.
// ============================================================================
`default_nettype none

module qpd_back (
   input  wire                     clock,
   input  wire                     reset,
   input  qpd_pkg::qpd_entry_type  head,
   input  wire                     empty,
   output logic                    pop,
   output logic                    rsp_valid,
   output qpd_pkg::qpd_rsp_type    rsp_payload,
   input  wire                     rsp_stall
);

   logic [1:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   qpd_pkg::qpd_rsp_type data_ff, data_in;
   logic                 load;
   logic                 at_last;

   assign load    = (!valid_ff || !rsp_stall) && !empty;
   assign at_last = (idx_ff == 2'(head.num - 2'd1));
   assign pop     = load && at_last;

   always_comb begin
      data_in      = '0;
      data_in.last = at_last;
      if (head.report && at_last) begin
         data_in.kind        = qpd_pkg::KIND_REPORT;
         data_in.line_length = head.length;
         data_in.soft_break  = head.soft_end;
      end else begin
         data_in.kind = qpd_pkg::KIND_BYTE;
         case (idx_ff)
            2'd0:    data_in.decoded_byte = head.data0;
            2'd1:    data_in.decoded_byte = head.data1;
            default: data_in.decoded_byte = head.data2;
         endcase
      end
      idx_in   = load ? (at_last ? 2'd0 : 2'(idx_ff + 2'd1)) : idx_ff;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

>>> rtl/quoted_printable_line_decoder.sv
// ============================================================================
// Quoted-printable line decoder
// Streams one encoded text line in, decoded bytes and a line report out.
// ============================================================================
// Throughput: one encoded byte is taken per clock while the four-entry result
// queue has room. Each item produces zero to three results, and the output
// register hands out one result per clock unless stalled, so an item that
// expands to two or three results (a broken escape, or an escape cut by the
// line end) needs one output transfer per result; the queue absorbs such
// bursts, and the output register loads each result from the queue head.
`default_nettype none

module quoted_printable_line_decoder (
   input  wire                    clock,
   input  wire                    reset,
   // encoded input transfers
   input  wire                    req_valid,
   input  qpd_pkg::qpd_req_type   req_payload,
   output logic                   req_stall,
   // decoded result transfers
   output logic                   rsp_valid,
   output qpd_pkg::qpd_rsp_type   rsp_payload,
   input  wire                    rsp_stall
);

   // front end -> queue
   logic                   push;
   qpd_pkg::qpd_entry_type push_entry;
   logic                   queue_full;
   // queue -> output stage
   qpd_pkg::qpd_entry_type head;
   logic                   queue_empty;
   logic                   pop;

   // Escape state machine, line counter; one entry per item with results.
   qpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decouples input acceptance from output stalls.
   qpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // Serializes each entry into single result transfers.
   qpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

>>> rtl/qpd_checker.sv
// ============================================================================
// Decoder port checker
// Checks port behavior of the line decoder over time.
// ============================================================================
`default_nettype none

module qpd_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input qpd_pkg::qpd_req_type  req_payload,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input qpd_pkg::qpd_rsp_type  rsp_payload,
   input wire                   rsp_stall
);

   // stalled input holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("input changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a report always closes its item's results
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == qpd_pkg::KIND_REPORT |-> rsp_payload.last)
      else $error("line report not marked last");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == qpd_pkg::KIND_BYTE |->
         rsp_payload.line_length == '0 && !rsp_payload.soft_break)
      else $error("byte result carries report fields");

endmodule

bind quoted_printable_line_decoder qpd_checker u_qpd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_payload (req_payload),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload),
   .rsp_stall   (rsp_stall)
);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Quoted-printable line decoder testbench
// Feeds encoded lines through the decoder and checks every decoded byte and
// line report against a cycle-free predictor, under random input gaps and
// random result stalls. Covers escapes, broken escapes, soft breaks, empty
// lines and lines cut in the middle of an escape.
// ============================================================================

module tb_top;

   localparam int CYCLE_LIMIT  = 1_000_000;
   // settling margin after every owed result has come back
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_CHARS = 220;
   localparam int MAX_PRINTED  = 30;
   localparam int REPORT_BITS  = qpd_pkg::REPORT_WIDTH;
   localparam longint unsigned REPORT_MAX = (64'd1 << qpd_pkg::REPORT_WIDTH) - 1;

   // one queued encoded character, or a marker that holds the sender until
   // every result owed so far has come back
   typedef struct {
      qpd_pkg::qpd_req_type chr;
      bit                   drain_first;
   } encoded_entry_type;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   qpd_pkg::qpd_req_type req_payload = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   qpd_pkg::qpd_rsp_type rsp_payload;
   logic                 rsp_stall   = 1'b0;

   encoded_entry_type    encoded_queue[$];
   qpd_pkg::qpd_rsp_type decoded_due[$];
   qpd_pkg::qpd_rsp_type front_rsp;

   // predictor state: mirrors what the decoder holds for the current line
   qpd_pkg::qpd_mode_type            line_mode  = qpd_pkg::MODE_PLAIN;
   logic [7:0]                       held_digit = '0;
   logic [qpd_pkg::LENGTH_WIDTH-1:0] line_count = '0;

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  chars_taken   = 0;
   int  bytes_checked = 0;
   int  lines_checked = 0;
   int  lines_queued  = 0;
   bit  char_accepted = 1'b0;

   // sender burst/gap bookkeeping
   int                burst_left = 0;
   int                gap_left   = 0;
   bit                send_now;
   encoded_entry_type front_entry;

   // receiver stall pattern
   stall_style_type stall_style = STALL_NONE;
   int              stall_left  = 0;

   quoted_printable_line_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Character classes, kept independent of the design's own helpers
   // -------------------------------------------------------------------------
   function automatic bit hex_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= 8'h61) begin         // a..f
         return 4'(c - 8'h57);
      end else if (c >= 8'h41) begin // A..F
         return 4'(c - 8'h37);
      end else begin
         return 4'(c - 8'h30);
      end
   endfunction

   function automatic bit blank_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   task automatic push_decoded(input logic [7:0] b);
      qpd_pkg::qpd_rsp_type r;
      r = '0;
      r.kind = qpd_pkg::KIND_BYTE;
      r.decoded_byte = b;
      decoded_due.push_back(r);
      if (line_count != '1) begin
         line_count++;
      end
   endtask

   task automatic take_plain(input logic [7:0] c);
      if (c == qpd_pkg::CHAR_EQUALS) begin
         line_mode = qpd_pkg::MODE_EQ;
      end else begin
         push_decoded(c);
      end
   endtask

   // works out every result one accepted transfer causes
   task automatic decode_step(input qpd_pkg::qpd_req_type t);
      int                   base;
      qpd_pkg::qpd_rsp_type r;
      longint unsigned      n;
      base = decoded_due.size();
      if (t.end_of_line) begin
         r = '0;
         r.kind = qpd_pkg::KIND_REPORT;
         case (line_mode)
            qpd_pkg::MODE_EQ, qpd_pkg::MODE_SOFT: begin
               r.soft_break = 1'b1;
            end
            qpd_pkg::MODE_HEX: begin
               // escape cut by the line end: '=' and the digit go out as is
               push_decoded(qpd_pkg::CHAR_EQUALS);
               push_decoded(held_digit);
            end
            default: begin
            end
         endcase
         n = line_count;
         r.line_length = REPORT_BITS'((n > REPORT_MAX) ? REPORT_MAX : n);
         decoded_due.push_back(r);
         line_mode  = qpd_pkg::MODE_PLAIN;
         held_digit = '0;
         line_count = '0;
      end else begin
         case (line_mode)
            qpd_pkg::MODE_PLAIN: begin
               take_plain(t.byte_in);
            end
            qpd_pkg::MODE_EQ: begin
               if (hex_digit(t.byte_in)) begin
                  held_digit = t.byte_in;
                  line_mode  = qpd_pkg::MODE_HEX;
               end else if (blank_char(t.byte_in)) begin
                  line_mode = qpd_pkg::MODE_SOFT;
               end else begin
                  line_mode = qpd_pkg::MODE_PLAIN;
                  push_decoded(qpd_pkg::CHAR_EQUALS);
                  take_plain(t.byte_in);
               end
            end
            qpd_pkg::MODE_HEX: begin
               line_mode = qpd_pkg::MODE_PLAIN;
               if (hex_digit(t.byte_in)) begin
                  push_decoded({digit_value(held_digit), digit_value(t.byte_in)});
               end else begin
                  // broken escape: up to three results, a new '=' re-arms
                  push_decoded(qpd_pkg::CHAR_EQUALS);
                  push_decoded(held_digit);
                  take_plain(t.byte_in);
               end
               held_digit = '0;
            end
            default: begin
               // soft break: rest of the line is dropped
            end
         endcase
      end
      if (decoded_due.size() > base) begin
         decoded_due[decoded_due.size() - 1].last = 1'b1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Mismatch reporting; printing is capped, counting is not
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic add_char(input logic [7:0] c);
      encoded_entry_type e;
      e.chr.byte_in     = c;
      e.chr.end_of_line = 1'b0;
      e.drain_first     = 1'b0;
      encoded_queue.push_back(e);
   endtask

   // the byte rides along with a random value; the decoder must ignore it
   task automatic add_eol();
      encoded_entry_type e;
      e.chr.byte_in     = 8'($urandom_range(0, 255));
      e.chr.end_of_line = 1'b1;
      e.drain_first     = 1'b0;
      encoded_queue.push_back(e);
      lines_queued++;
   endtask

   task automatic add_drain();
      encoded_entry_type e;
      e.chr         = '0;
      e.drain_first = 1'b1;
      encoded_queue.push_back(e);
   endtask

   function automatic logic [7:0] rand_hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(0, 15));
      if (v < 4'd10) begin
         return 8'h30 + 8'(v);
      end else if ($urandom_range(0, 1) == 0) begin
         return 8'h41 + 8'(v) - 8'd10;
      end else begin
         return 8'h61 + 8'(v) - 8'd10;
      end
   endfunction

   function automatic logic [7:0] rand_blank();
      int idx;
      idx = $urandom_range(0, 5);
      return (idx < 5) ? 8'(8'h09 + idx) : 8'h20;
   endfunction

   function automatic logic [7:0] rand_literal();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == qpd_pkg::CHAR_EQUALS);
      return c;
   endfunction

   // mostly well-formed text with escapes, salted with broken escapes and
   // raw bytes; the line end is plain, a soft break or a cut escape
   task automatic add_random_line();
      int tokens;
      int pick;
      tokens = $urandom_range(0, 18);
      repeat (tokens) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            add_char(rand_literal());
         end else if (pick < 75) begin
            add_char(qpd_pkg::CHAR_EQUALS);
            add_char(rand_hex_char());
            add_char(rand_hex_char());
         end else if (pick < 85) begin
            add_char(qpd_pkg::CHAR_EQUALS);
            add_char(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            add_char(qpd_pkg::CHAR_EQUALS);
            add_char(rand_hex_char());
            add_char(8'($urandom_range(0, 255)));
         end else begin
            add_char(8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         add_char(qpd_pkg::CHAR_EQUALS);
         add_char(rand_blank());
         repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
         add_char(qpd_pkg::CHAR_EQUALS);
      end else if (pick < 28) begin
         add_char(qpd_pkg::CHAR_EQUALS);
         add_char(rand_hex_char());
      end
      add_eol();
   endtask

   // -------------------------------------------------------------------------
   // Driver: presents queued characters at the falling edge, in bursts with
   // random gaps; a drain marker keeps valid low until nothing is owed
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      // a stalled transfer keeps valid and payload exactly as they are
      if (!reset && !(req_valid && !char_accepted)) begin
         send_now = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (encoded_queue.size() > 0) begin
            if (encoded_queue[0].drain_first) begin
               if (decoded_due.size() == 0) begin
                  front_entry = encoded_queue.pop_front();
               end
            end else begin
               front_entry = encoded_queue.pop_front();
               send_now    = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= send_now;
         if (send_now) begin
            req_payload <= front_entry.chr;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver stall pattern: styles switch at random intervals, so there
   // are long stretches with no stall as well as heavy ones
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((cycle_count % 5) < 2);
      endcase
   end

   // -------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge; a result transfer is
   // checked against the oldest owed result, an input transfer feeds the
   // predictor
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      char_accepted = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_due.size() == 0) begin
               report_mismatch("result transfer with nothing owed");
            end else begin
               front_rsp = decoded_due.pop_front();
               if (front_rsp.kind == qpd_pkg::KIND_REPORT) begin
                  lines_checked++;
               end else begin
                  bytes_checked++;
               end
               if (rsp_payload.kind !== front_rsp.kind) begin
                  report_mismatch($sformatf("kind %0b, wanted %0b",
                                            rsp_payload.kind, front_rsp.kind));
               end
               if (rsp_payload.decoded_byte !== front_rsp.decoded_byte) begin
                  report_mismatch($sformatf("decoded_byte %02h, wanted %02h",
                                            rsp_payload.decoded_byte,
                                            front_rsp.decoded_byte));
               end
               if (rsp_payload.line_length !== front_rsp.line_length) begin
                  report_mismatch($sformatf("line_length %0d, wanted %0d",
                                            rsp_payload.line_length,
                                            front_rsp.line_length));
               end
               if (rsp_payload.soft_break !== front_rsp.soft_break) begin
                  report_mismatch($sformatf("soft_break %0b, wanted %0b",
                                            rsp_payload.soft_break,
                                            front_rsp.soft_break));
               end
               if (rsp_payload.last !== front_rsp.last) begin
                  report_mismatch($sformatf("last %0b, wanted %0b",
                                            rsp_payload.last, front_rsp.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            char_accepted = 1'b1;
            chars_taken++;
            decode_step(req_payload);
         end
      end
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still owed",
                  cycle_count, decoded_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int first;
      int line_no;

      // directed: byte extremes, escapes in both cases, an FF escape
      add_char(8'h00);
      add_char(8'hFF);
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h34); add_char(8'h31);   // =41
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h66); add_char(8'h46);   // =fF
      add_eol();
      // '=' before a non-hex byte, broken second digit, broken by a new '=',
      // '=' twice, then a soft break with trailing text to drop
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h47);                     // =G
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h33); add_char(8'h7A);   // =3z
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h41);
      add_char(qpd_pkg::CHAR_EQUALS);                                      // =A=
      add_char(qpd_pkg::CHAR_EQUALS);
      add_char(8'h20);
      add_char(8'h78);
      add_eol();
      // '=' alone at the line end is a soft break; empty line after it
      add_char(qpd_pkg::CHAR_EQUALS);
      add_eol();
      add_eol();
      // escape cut by the line end after one digit
      add_char(8'h71); add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h63);
      add_eol();
      add_drain();

      // random lines, with the sender made to drain now and then
      first   = encoded_queue.size();
      line_no = 0;
      while (encoded_queue.size() - first < RANDOM_CHARS) begin
         add_random_line();
         line_no++;
         if (line_no % 10 == 0) begin
            add_drain();
         end
      end
      add_drain();

      // an escape and a short line to close the run
      add_char(qpd_pkg::CHAR_EQUALS); add_char(8'h34); add_char(8'h41);
      add_eol();
      add_char(8'h6F); add_char(8'h6B);
      add_eol();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (encoded_queue.size() != 0 || req_valid || decoded_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Decoded %0d encoded transfers over %0d lines in %0d cycles.",
               chars_taken, lines_queued, cycle_count);
      $display("Checked %0d decoded bytes and %0d line reports across escapes and soft breaks.",
               bytes_checked, lines_checked);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
